// ===== hdl/bbsh_pkg.sv =====
package bbsh_pkg;

    // Storage widths of the nesting depth, the body counters, the outputs and the hash
    localparam int DEPTH_BITS = 16;
    localparam int COUNT_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int HASH_BITS  = 64;

    localparam logic [HASH_BITS-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // Characters the lexer reacts to
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic                  active;
        logic [DEPTH_BITS-1:0] depth;
        logic                  in_line;
        logic                  in_block;
        logic                  in_string;
        logic                  slash_pending;
        logic [7:0]            prev_byte;
        logic [COUNT_BITS-1:0] len;
        logic [COUNT_BITS-1:0] nl;
        logic [HASH_BITS-1:0]  hash;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        active:        1'b0,
        depth:         '0,
        in_line:       1'b0,
        in_block:      1'b0,
        in_string:     1'b0,
        slash_pending: 1'b0,
        prev_byte:     8'h00,
        len:           '0,
        nl:            '0,
        hash:          FNV_BASIS
    };

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [OUT_BITS-1:0]  length;
        logic [OUT_BITS-1:0]  newlines;
        logic [HASH_BITS-1:0] hash;
    } scan_result_t;

    // One FNV-1a round. Prime 0x100000001B3 = 2^40 + 2^8 + 0xB3,
    // 0xB3 = 2^7 + 2^5 + 2^4 + 2^1 + 1, so the product is a shift-add.
    function automatic logic [HASH_BITS-1:0] fnv_step(
        input logic [HASH_BITS-1:0] h,
        input logic [7:0]           c
    );
        logic [HASH_BITS-1:0] x;
        x = h ^ {{(HASH_BITS-8){1'b0}}, c};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Counter to output width, saturating when the counter is wider
    function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] upper;
        upper = v >> OUT_BITS;
        if ((COUNT_BITS > OUT_BITS) && (upper != '0)) begin
            return '1;
        end
        return OUT_BITS'(v);
    endfunction

endpackage

// ===== hdl/bbsh_scan.sv =====
module bbsh_scan
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic [7:0]             text_byte,
    input  logic                   start_scan,
    input  logic                   end_of_text,
    output bbsh_pkg::scan_result_t res
);

    bbsh_pkg::scan_state_t st_reg;
    bbsh_pkg::scan_state_t st_next;
    bbsh_pkg::scan_state_t cur;
    bbsh_pkg::scan_state_t upd;
    logic                  closed;

    always_comb
    begin
        cur = st_reg;
        if (start_scan)
        begin
            cur        = bbsh_pkg::SCAN_CLEAR;
            cur.active = 1'b1;
        end

        upd    = cur;
        closed = 1'b0;
        res    = '0;

        if (cur.active)
        begin
            if (cur.len != '1)
            begin
                upd.len = cur.len + 1'b1;
            end
            if ((text_byte == bbsh_pkg::CH_NL) && (cur.nl != '1))
            begin
                upd.nl = cur.nl + 1'b1;
            end
            upd.hash = bbsh_pkg::fnv_step(cur.hash, text_byte);

            if (cur.in_line)
            begin
                if (text_byte == bbsh_pkg::CH_NL)
                begin
                    upd.in_line = 1'b0;
                end
            end
            else if (cur.in_block)
            begin
                if ((text_byte == bbsh_pkg::CH_SLASH) && (cur.prev_byte == bbsh_pkg::CH_STAR))
                begin
                    upd.in_block = 1'b0;
                end
            end
            else if (cur.in_string)
            begin
                if ((text_byte == bbsh_pkg::CH_QUOTE) &&
                    (cur.prev_byte != bbsh_pkg::CH_BSLASH))
                begin
                    upd.in_string = 1'b0;
                end
            end
            else if (cur.slash_pending && (text_byte == bbsh_pkg::CH_SLASH))
            begin
                upd.slash_pending = 1'b0;
                upd.in_line       = 1'b1;
            end
            else if (cur.slash_pending && (text_byte == bbsh_pkg::CH_STAR))
            begin
                upd.slash_pending = 1'b0;
                upd.in_block      = 1'b1;
            end
            else
            begin
                upd.slash_pending = 1'b0;
                case (text_byte)
                    bbsh_pkg::CH_SLASH:  upd.slash_pending = 1'b1;
                    bbsh_pkg::CH_QUOTE:  upd.in_string     = 1'b1;
                    bbsh_pkg::CH_LBRACE:
                    begin
                        if (cur.depth != '1)
                        begin
                            upd.depth = cur.depth + 1'b1;
                        end
                    end
                    bbsh_pkg::CH_RBRACE:
                    begin
                        if (cur.depth != '0)
                        begin
                            upd.depth = cur.depth - 1'b1;
                            closed    = (cur.depth == bbsh_pkg::DEPTH_BITS'(1));
                        end
                    end
                    default: ;
                endcase
            end
            upd.prev_byte = text_byte;

            if (closed)
            begin
                res.valid    = 1'b1;
                res.found    = 1'b1;
                res.length   = bbsh_pkg::sat_out(upd.len);
                res.newlines = bbsh_pkg::sat_out(upd.nl);
                res.hash     = upd.hash;
                upd          = bbsh_pkg::SCAN_CLEAR;
            end
            else if (end_of_text)
            begin
                // unmatched: all result fields stay zero
                res.valid = 1'b1;
                upd       = bbsh_pkg::SCAN_CLEAR;
            end
        end
    end

    assign st_next = step_en ? upd : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= bbsh_pkg::SCAN_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

`ifndef SYNTH
    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({st_reg.in_line, st_reg.in_block, st_reg.in_string}))
        else $error("more than one lexer mode active");

    a_slash_only_in_code: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.slash_pending |-> !(st_reg.in_line || st_reg.in_block || st_reg.in_string))
        else $error("pending slash inside comment or string");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.valid) |=> (!st_reg.active && (st_reg.depth == '0)))
        else $error("scan state not cleared after result");

    a_found_has_body: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.found) |-> (res.length >= bbsh_pkg::OUT_BITS'(1)))
        else $error("match reported with empty body");
`endif

endmodule

// ===== hdl/brace_block_scanner_hash.sv =====
// Channel | handshake             | payload
// --------+-----------------------+--------------------------------------------------
// input   | in_valid / in_stall   | text_byte, start_scan, end_of_text
// output  | out_valid / out_stall | found, body_length, body_newlines, block_hash
//
// A byte transaction is captured in the hold register; when the result register can take
// a result, the scan logic updates the state and any result lands in the output register.
// Sustained rate: one byte per cycle unless a stalled result holds the scan logic.
// Reset (rst_n low, async) clears the scan state and empties both registers.
// out_stall holds the result register; the hold register then stalls the input side.
module brace_block_scanner_hash
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        start_scan,
    input  logic        end_of_text,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [31:0] body_length,
    output logic [31:0] body_newlines,
    output logic [63:0] block_hash
);

    // input hold register
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       hold_start_reg;
    logic       hold_last_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    bbsh_pkg::scan_result_t out_data_reg;

    bbsh_pkg::scan_result_t step_res;
    logic                   advance;
    logic                   in_take;

    // A held byte moves through the scan logic only when the result register is free
    // or is being emptied this cycle, so a result never overwrites one still waiting.
    assign advance  = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = hold_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && step_res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_byte_reg  <= text_byte;
            hold_start_reg <= start_scan;
            hold_last_reg  <= end_of_text;
        end
        if (advance && step_res.valid)
        begin
            out_data_reg <= step_res;
        end
    end

    // Lexer, depth tracking, counters and hash
    bbsh_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .text_byte   (hold_byte_reg),
        .start_scan  (hold_start_reg),
        .end_of_text (hold_last_reg),
        .res         (step_res)
    );

    assign out_valid     = out_valid_reg;
    assign found         = out_data_reg.found;
    assign body_length   = out_data_reg.length;
    assign body_newlines = out_data_reg.newlines;
    assign block_hash    = out_data_reg.hash;

`ifndef SYNTH
    a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (hold_valid_reg && out_valid_reg))
        else $error("input stalled with nothing blocking");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> ((body_length == 32'd0) && (block_hash == 64'd0)))
        else $error("unmatched result carries data");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(advance && step_res.valid))
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // FNV-1a 64 multiplier
    localparam logic [63:0] FNV_MULT = 64'h0000_0100_0000_01B3;

    // Cycles with no transaction on either channel before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    // Window (in ns) where neither side idles or stalls
    localparam longint CALM_FROM = 2000;
    localparam longint CALM_TO   = 5000;

    // Random byte count for the mixed-text phase
    localparam int RANDOM_BYTES = 480;

    typedef struct packed {
        logic [7:0] ch;
        logic       st;
        logic       eot;
        logic       drain;   // marker: no byte, hold off until all results are back
    } text_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] length;
        logic [31:0] newlines;
        logic [63:0] hash;
    } body_match_t;

    // Kinds of fragment the random body generator strings together
    typedef enum int {
        FR_ANY,
        FR_OPEN,
        FR_CLOSE,
        FR_LINE_CMT,
        FR_BLOCK_CMT,
        FR_STRING,
        FR_NEWLINE,
        FR_SLASH
    } body_frag_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        start_scan = 1'b0;
    logic        end_of_text = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [31:0] body_length;
    logic [31:0] body_newlines;
    logic [63:0] block_hash;

    text_item_t  byte_q[$];      // bytes waiting to be offered to the scanner
    body_match_t match_q[$];     // predicted scan results, oldest first
    int          queued_bytes = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    // Predictor copy of the scanner state
    logic                            scanning;
    logic [bbsh_pkg::DEPTH_BITS-1:0] depth;
    logic                            in_lc;
    logic                            in_bc;
    logic                            in_str;
    logic                            slash_wait;
    logic [7:0]                      prev_c;
    logic [bbsh_pkg::COUNT_BITS-1:0] len_cnt;
    logic [bbsh_pkg::COUNT_BITS-1:0] nl_cnt;
    logic [63:0]                     hash_acc;

    brace_block_scanner_hash DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .start_scan    (start_scan),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .body_length   (body_length),
        .body_newlines (body_newlines),
        .block_hash    (block_hash)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------

    task automatic clear_scan();
        scanning   = 1'b0;
        depth      = '0;
        in_lc      = 1'b0;
        in_bc      = 1'b0;
        in_str     = 1'b0;
        slash_wait = 1'b0;
        prev_c     = 8'h00;
        len_cnt    = '0;
        nl_cnt     = '0;
        hash_acc   = bbsh_pkg::FNV_BASIS;
    endtask

    // Counters are COUNT_BITS wide; the outputs clip at 32 bits
    function automatic logic [31:0] clip32(input logic [bbsh_pkg::COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // Advance the predictor by one accepted byte; queue any result it causes
    task automatic predict_byte(input logic [7:0] c, input logic st, input logic eot);
        logic        closed;
        body_match_t res;
        if (st) begin
            clear_scan();
            scanning = 1'b1;
        end
        if (scanning) begin
            closed = 1'b0;
            if (len_cnt != '1)
                len_cnt = len_cnt + 1'b1;
            if (c == bbsh_pkg::CH_NL && nl_cnt != '1)
                nl_cnt = nl_cnt + 1'b1;
            hash_acc = (hash_acc ^ {56'd0, c}) * FNV_MULT;

            // Lexer: comments and strings hide braces; a slash waits one byte
            if (in_lc) begin
                if (c == bbsh_pkg::CH_NL)
                    in_lc = 1'b0;
            end else if (in_bc) begin
                if (c == bbsh_pkg::CH_SLASH && prev_c == bbsh_pkg::CH_STAR)
                    in_bc = 1'b0;
            end else if (in_str) begin
                if (c == bbsh_pkg::CH_QUOTE && prev_c != bbsh_pkg::CH_BSLASH)
                    in_str = 1'b0;
            end else if (slash_wait && c == bbsh_pkg::CH_SLASH) begin
                slash_wait = 1'b0;
                in_lc = 1'b1;
            end else if (slash_wait && c == bbsh_pkg::CH_STAR) begin
                slash_wait = 1'b0;
                in_bc = 1'b1;
            end else begin
                slash_wait = 1'b0;
                if (c == bbsh_pkg::CH_SLASH) begin
                    slash_wait = 1'b1;
                end else if (c == bbsh_pkg::CH_QUOTE) begin
                    in_str = 1'b1;
                end else if (c == bbsh_pkg::CH_LBRACE) begin
                    if (depth != '1)
                        depth = depth + 1'b1;
                end else if (c == bbsh_pkg::CH_RBRACE) begin
                    if (depth != '0) begin
                        depth = depth - 1'b1;
                        closed = (depth == '0);
                    end
                end
            end
            prev_c = c;

            if (closed) begin
                res.found    = 1'b1;
                res.length   = clip32(len_cnt);
                res.newlines = clip32(nl_cnt);
                res.hash     = hash_acc;
                match_q = {match_q, res};
                clear_scan();
            end else if (eot) begin
                // Unmatched at end of text: everything reads zero
                res = '0;
                match_q = {match_q, res};
                clear_scan();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic put(input logic [7:0] c, input logic st, input logic eot);
        text_item_t it;
        it = '{ch: c, st: st, eot: eot, drain: 1'b0};
        byte_q = {byte_q, it};
        queued_bytes++;
    endtask

    task automatic put_drain();
        text_item_t it;
        it = '{ch: 8'h00, st: 1'b0, eot: 1'b0, drain: 1'b1};
        byte_q = {byte_q, it};
    endtask

    // Bytes with no start mark; ignored unless the block before was left open
    task automatic put_noise(input int n);
        text_item_t it;
        repeat (n) begin
            it = '{ch: 8'($urandom_range(0, 255)), st: 1'b0,
                   eot: 1'($urandom_range(0, 1)), drain: 1'b0};
            byte_q = {byte_q, it};
        end
    endtask

    // Filler for comment and string bodies, heavy on the lexer's special bytes
    task automatic put_filler(input int n);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: put(bbsh_pkg::CH_LBRACE, 1'b0, 1'b0);
                1: put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
                2: put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
                3: put(bbsh_pkg::CH_BSLASH, 1'b0, 1'b0);
                4: put(bbsh_pkg::CH_STAR, 1'b0, 1'b0);
                5: put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                default: put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            endcase
        end
    endtask

    // One block: opening brace, a few fragments, then mostly a proper close
    task automatic gen_block();
        int         opens;
        body_frag_t kind;
        int         ending;
        opens = 0;
        put(bbsh_pkg::CH_LBRACE, 1'b1, 1'b0);
        repeat ($urandom_range(1, 6)) begin
            kind = body_frag_t'($urandom_range(0, 7));
            case (kind)
                FR_ANY:
                    put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                FR_OPEN: begin
                    put(bbsh_pkg::CH_LBRACE, 1'b0, 1'b0);
                    opens++;
                end
                FR_CLOSE:
                    if (opens > 0) begin
                        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
                        opens--;
                    end else begin
                        put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    end
                FR_LINE_CMT: begin
                    put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                    put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                    put_filler($urandom_range(0, 4));
                    put(bbsh_pkg::CH_NL, 1'b0, 1'b0);
                end
                FR_BLOCK_CMT: begin
                    put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                    put(bbsh_pkg::CH_STAR, 1'b0, 1'b0);
                    put_filler($urandom_range(0, 4));
                    put(bbsh_pkg::CH_STAR, 1'b0, 1'b0);
                    put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                end
                FR_STRING: begin
                    put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
                    put_filler($urandom_range(0, 4));
                    if ($urandom_range(0, 1)) begin
                        put(bbsh_pkg::CH_BSLASH, 1'b0, 1'b0);
                        put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
                    end
                    put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
                end
                FR_NEWLINE:
                    put(bbsh_pkg::CH_NL, 1'b0, 1'b0);
                FR_SLASH: begin
                    put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
                    put_filler(1);
                end
                default: ;
            endcase
        end
        ending = $urandom_range(0, 9);
        if (ending == 0) begin
            // text cut short inside the block
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else if (ending != 1) begin
            // ending 1 leaves the block open; the next start drops it
            repeat (opens) put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
            put(bbsh_pkg::CH_RBRACE, 1'b0, 1'($urandom_range(0, 3) == 0));
        end
        put_noise($urandom_range(0, 2));
    endtask

    // ------------------------------------------------------------------
    // Idle / stall policy shared by both sides
    // ------------------------------------------------------------------

    function automatic logic take_break();
        longint now;
        now = $time;
        if (now >= CALM_FROM && now < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: predicts each accepted byte, then offers the next one
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin : drive_proc
        text_item_t nxt;
        logic       offer;
        if (!rst_n) begin
            in_valid    <= 1'b0;
            text_byte   <= 8'h00;
            start_scan  <= 1'b0;
            end_of_text <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predict_byte(text_byte, start_scan, end_of_text);

            // A stalled transaction holds; otherwise the slot is free
            if (!in_valid || !in_stall) begin
                offer = 1'b0;
                if (byte_q.size() != 0) begin
                    if (byte_q[0].drain) begin
                        // hold off until the scanner has handed back every result
                        if (match_q.size() == 0)
                            void'(byte_q.pop_front());
                    end else if (!take_break()) begin
                        offer = 1'b1;
                    end
                end
                if (offer) begin
                    nxt = byte_q.pop_front();
                    in_valid    <= 1'b1;
                    text_byte   <= nxt.ch;
                    start_scan  <= nxt.st;
                    end_of_text <= nxt.eot;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each result transaction against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin : check_proc
        body_match_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (match_q.size() == 0) begin
                    report_mismatch("result with none pending", {63'd0, found}, 64'd0);
                end else begin
                    want = match_q.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", 64'(found), 64'(want.found));
                    if (body_length !== want.length)
                        report_mismatch("body_length", 64'(body_length), 64'(want.length));
                    if (body_newlines !== want.newlines)
                        report_mismatch("body_newlines", 64'(body_newlines),
                                        64'(want.newlines));
                    if (block_hash !== want.hash)
                        report_mismatch("block_hash", block_hash, want.hash);
                end
            end
            out_stall <= take_break();
        end
    end

    // Hang detector: counts cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HANG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------

    initial begin
        logic drained;
        clear_scan();
        drained = 1'b0;

        // Directed part
        put(8'hFF, 1'b0, 1'b1);                     // no scan running: ignored at end of text
        put(8'h00, 1'b1, 1'b0);                     // start on a non-brace byte
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);       // close at depth zero is ignored
        put(bbsh_pkg::CH_LBRACE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);       // match
        put(bbsh_pkg::CH_LBRACE, 1'b1, 1'b0);
        put(bbsh_pkg::CH_LBRACE, 1'b1, 1'b0);       // restart drops the running scan
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_LBRACE, 1'b1, 1'b0);
        put(bbsh_pkg::CH_SLASH, 1'b0, 1'b1);        // trailing slash, text ends unmatched
        put(bbsh_pkg::CH_LBRACE, 1'b1, 1'b0);
        put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);        // line comment hides a close
        put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_NL, 1'b0, 1'b0);
        put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);        // block comment hides a close
        put(bbsh_pkg::CH_STAR, 1'b0, 1'b0);
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_STAR, 1'b0, 1'b0);
        put(bbsh_pkg::CH_SLASH, 1'b0, 1'b0);
        put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);        // string with an escaped quote
        put(bbsh_pkg::CH_BSLASH, 1'b0, 1'b0);
        put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_QUOTE, 1'b0, 1'b0);
        put(bbsh_pkg::CH_RBRACE, 1'b0, 1'b1);       // match on the last byte of the text

        // Random blocks, with one full drain partway through
        queued_bytes = 0;
        while (queued_bytes < RANDOM_BYTES) begin
            gen_block();
            if (!drained && queued_bytes >= RANDOM_BYTES / 2) begin
                put_drain();
                drained = 1'b1;
            end
        end
        put_drain();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== brace_block_scanner_hash.f =====
hdl/bbsh_pkg.sv
hdl/bbsh_scan.sv
hdl/brace_block_scanner_hash.sv
verif/testbench.sv
